@@ design/dcma_pkg.sv @@
// Shared types and constants of the dual-channel moving average.
package dcma_pkg;

    // Register word index of window_len on the APB port
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

    // Reset value of window_len
    localparam logic [7:0] WINDOW_LEN_RESET = 8'd8;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command control: channel and whether the request produces an average
    typedef struct packed {
        logic ch;
        logic emit;
    } t_cmd_ctrl;

    // Back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic dividing;
    } t_back_stat;

endpackage

@@ design/dcma_front.sv @@
// Front end: takes requests, tracks fill counts and ring pointers, issues commands.
module dcma_front #(
    parameter int NW = 9,
    parameter int PW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  logic [NW-1:0]        i_win_len,
    input  logic                 i_valid,
    input  logic                 i_channel,
    output logic                 o_stall,
    input  logic                 i_full,
    output logic                 o_push,
    output dcma_pkg::t_cmd_ctrl  o_ctrl,
    output logic [PW-1:0]        o_slot
);

    logic [NW-1:0] r_fill [2];
    logic [PW-1:0] r_ptr  [2];
    logic [NW-1:0] fill_sel;
    logic [NW-1:0] ptr_inc;
    logic          emit;

    assign fill_sel = r_fill[i_channel];
    assign emit     = (fill_sel >= i_win_len);
    assign ptr_inc  = NW'(r_ptr[i_channel]) + NW'(1);

    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign o_ctrl.ch   = i_channel;
    assign o_ctrl.emit = emit;
    // while filling the pointer is still zero, so the slot is the fill count
    assign o_slot      = emit ? r_ptr[i_channel] : PW'(fill_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_ptr[0]  <= '0;
            r_ptr[1]  <= '0;
        end else if (o_push) begin
            if (!emit) begin
                r_fill[i_channel] <= fill_sel + NW'(1);
            end else if (ptr_inc >= i_win_len) begin
                r_ptr[i_channel] <= '0;
            end else begin
                r_ptr[i_channel] <= PW'(ptr_inc);
            end
        end
    end

endmodule

@@ design/dcma_queue.sv @@
// Small command queue between front and back ends.
module dcma_queue #(
    parameter int W     = 20,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    input  logic                       i_pop,
    output logic [W-1:0]               o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_data [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ design/dcma_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module dcma_div #(
    parameter int SW = 24,
    parameter int NW = 9,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_busy,
    output logic [QW-1:0] o_quotient
);

    localparam int KW = $clog2(SW+1);

    logic [SW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_div;
    logic [KW-1:0] r_cnt;
    logic          r_neg;
    logic [NW:0]   shifted;
    logic [NW:0]   diff;
    logic [SW-1:0] signed_quo;

    assign shifted    = {r_rem, r_quo[SW-1]};
    assign diff       = shifted - {1'b0, r_div};
    assign o_busy     = (r_cnt != '0);
    assign signed_quo = r_neg ? (~r_quo + SW'(1)) : r_quo;
    assign o_quotient = signed_quo[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_quo <= i_dividend[SW-1] ? (~i_dividend + SW'(1)) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (o_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                r_rem <= diff[NW-1:0];
                r_quo <= {r_quo[SW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[NW-1:0];
                r_quo <= {r_quo[SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= KW'(SW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - KW'(1);
        end
    end

endmodule

@@ design/dcma_back.sv @@
// Back end: sample rings, window sums, division and the output register.
module dcma_back #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int NW           = 9,
    parameter int PW           = 8,
    parameter int SW           = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic [NW-1:0]            i_win_len,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  dcma_pkg::t_cmd_ctrl      i_ctrl,
    input  logic [PW-1:0]            i_slot,
    input  logic [SAMPLE_WIDTH-1:0]  i_sample,
    output logic                     o_valid,
    output logic                     o_out_channel,
    output logic [SAMPLE_WIDTH-1:0]  o_average,
    input  logic                     i_stall,
    output dcma_pkg::t_back_stat     o_stat
);

    localparam int EXT = SW - SAMPLE_WIDTH;
    // each channel owns a power-of-two slot range, addressed as {channel, slot}
    localparam int RING_DEPTH = 2 ** (PW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [SAMPLE_WIDTH-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_rdata;
    logic [SW-1:0]           r_sum [2];
    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic                    r_ch;
    logic [PW-1:0]           r_slot;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_ovalid;
    logic                    r_och;
    logic [SAMPLE_WIDTH-1:0] r_oavg;

    logic                    pop_fill;
    logic                    pop_emit;
    logic                    ring_we;
    logic [PW:0]             ring_waddr;
    logic [SAMPLE_WIDTH-1:0] ring_wdata;
    logic [SW-1:0]           new_ext;
    logic [SW-1:0]           old_ext;
    logic [SW-1:0]           held_ext;
    logic                    div_busy;
    logic [SAMPLE_WIDTH-1:0] div_quo;
    logic                    load_out;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign pop_fill = o_pop && !i_ctrl.emit;
    assign pop_emit = o_pop && i_ctrl.emit;

    assign new_ext  = {{EXT{i_sample[SAMPLE_WIDTH-1]}}, i_sample};
    assign old_ext  = {{EXT{r_rdata[SAMPLE_WIDTH-1]}}, r_rdata};
    assign held_ext = {{EXT{r_sample[SAMPLE_WIDTH-1]}}, r_sample};

    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = {i_ctrl.ch, i_slot};
        ring_wdata = i_sample;
        if (pop_fill) begin
            ring_we = 1'b1;
        end else if (r_state == S_RD) begin
            ring_we    = 1'b1;
            ring_waddr = {r_ch, r_slot};
            ring_wdata = r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= ring_wdata;
        end
        if (pop_emit) begin
            r_rdata <= r_ring[{i_ctrl.ch, i_slot}];
        end
    end

    dcma_div #(
        .SW (SW),
        .NW (NW),
        .QW (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (pop_emit),
        .i_dividend (r_sum[i_ctrl.ch]),
        .i_divisor  (i_win_len),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign load_out = (r_state == S_DIV) && !div_busy && (!r_ovalid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (pop_emit) begin
                n_state = S_RD;
            end
            S_RD:    n_state = S_DIV;
            S_DIV:   if (load_out) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop_emit) begin
            r_ch     <= i_ctrl.ch;
            r_slot   <= i_slot;
            r_sample <= i_sample;
        end
        if (load_out) begin
            r_och  <= r_ch;
            r_oavg <= div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // window sums: add while filling, slide once the oldest sample is back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
        end else if (pop_fill) begin
            r_sum[i_ctrl.ch] <= r_sum[i_ctrl.ch] + new_ext;
        end else if (r_state == S_RD) begin
            r_sum[r_ch] <= r_sum[r_ch] - old_ext + held_ext;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_channel   = r_och;
    assign o_average       = r_oavg;
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.dividing = (r_state == S_DIV);

endmodule

@@ design/dual_channel_moving_average.sv @@
// Top level of the dual-channel boxcar moving average.
//
// Each request carries one signed sample for channel X (0) or Y (1). Per
// channel the block keeps a ring of the last window_len samples, a running
// sum and a fill count. The first window_len requests of a channel only fill
// the ring and give no result; every later request first yields the mean of
// the stored window (sum / window_len, truncated toward zero) and then
// replaces the oldest sample with the new one. window_len lives at APB byte
// address 0 (0 acts as 1, values above MAX_WINDOW saturate); writing it
// restarts filling on both channels, and must only be done while idle.
// Flow: the front end classifies a request in its accept cycle and queues
// it (two entries). In the back end a filling request is done as it is
// popped and leaves the back end idle; an averaging request holds it through
// the pop, which starts the bit-serial divider, a division over every bit of
// the window sum, and the output load, which waits while a held average is
// stalled; the ring read and the sum update run alongside the division. The
// ring is one RAM of two power-of-two halves with one write and one registered
// read port; it needs no clearing pass.
module dual_channel_moving_average #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample requests
    input  logic                    i_valid,
    input  logic                    i_channel,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_stall,
    // averages
    output logic                    o_valid,
    output logic                    o_out_channel,
    output logic [SAMPLE_WIDTH-1:0] o_average,
    input  logic                    i_stall,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int NW = $clog2(MAX_WINDOW + 1);   // holds 1..MAX_WINDOW
    localparam int PW = $clog2(MAX_WINDOW);       // ring slot
    localparam int SW = SAMPLE_WIDTH + PW;        // exact window sum
    localparam int CMD_W = $bits(dcma_pkg::t_cmd_ctrl) + PW + SAMPLE_WIDTH;
    localparam int QCW = $clog2(dcma_pkg::QUEUE_DEPTH + 1);

    logic [7:0]           r_window_len;
    logic                 cfg_wr;
    logic                 restart;
    logic [NW-1:0]        win_len;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [QCW-1:0]       q_count;
    logic [CMD_W-1:0]     q_din;
    logic [CMD_W-1:0]     q_dout;

    dcma_pkg::t_cmd_ctrl  f_ctrl;
    logic [PW-1:0]        f_slot;
    dcma_pkg::t_cmd_ctrl  b_ctrl;
    logic [PW-1:0]        b_slot;
    logic [SAMPLE_WIDTH-1:0] b_sample;
    dcma_pkg::t_back_stat bk_stat;

    // --- configuration register ---
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && (paddr[2:2] == dcma_pkg::REG_WINDOW_LEN);
    assign prdata  = (paddr[2:2] == dcma_pkg::REG_WINDOW_LEN) ? {24'd0, r_window_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= dcma_pkg::WINDOW_LEN_RESET;
        end else if (restart) begin
            r_window_len <= pwdata[7:0];
        end
    end

    // effective window: zero means one, large values clamp to MAX_WINDOW
    always_comb begin
        if (r_window_len == 8'd0) begin
            win_len = NW'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            win_len = NW'(MAX_WINDOW);
        end else begin
            win_len = NW'(r_window_len);
        end
    end

    // --- front end: classify and queue ---
    dcma_front #(
        .NW (NW),
        .PW (PW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_win_len (win_len),
        .i_valid   (i_valid),
        .i_channel (i_channel),
        .o_stall   (o_stall),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_ctrl    (f_ctrl),
        .o_slot    (f_slot)
    );

    assign q_din = {f_ctrl, f_slot, i_sample};

    dcma_queue #(
        .W     (CMD_W),
        .DEPTH (dcma_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {b_ctrl, b_slot, b_sample} = q_dout;

    // --- back end: ring, sums, divider, output register ---
    dcma_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .NW           (NW),
        .PW           (PW),
        .SW           (SW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_win_len     (win_len),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .i_ctrl        (b_ctrl),
        .i_slot        (b_slot),
        .i_sample      (b_sample),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_average     (o_average),
        .i_stall       (i_stall),
        .o_stat        (bk_stat)
    );

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCW'(dcma_pkg::QUEUE_DEPTH))
        else $error("command queue over depth");

    // back end only takes a command when idle and one is waiting
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (bk_stat.idle && !q_empty))
        else $error("command popped while busy or empty");

    // a fresh average only follows a division
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(bk_stat.dividing))
        else $error("average raised without a division");
`endif

endmodule
